// ----- rtl/ctvi_pkg.sv -----
// Shared types and constants for the cube trilinear vector interpolator.
// No dependencies.
`timescale 1ns / 1ps
package ctvi_pkg;

  localparam int CW     = 16;  // coordinate and vector width, signed
  localparam int SIZE_W = 15;  // cube edge length width, unsigned
  localparam int ADDR_W = 4;   // APB byte address width

  localparam logic signed [CW-1:0] ORIGIN_X_RST = 16'sd0;
  localparam logic signed [CW-1:0] ORIGIN_Y_RST = 16'sd2048;
  localparam logic signed [CW-1:0] ORIGIN_Z_RST = 16'sd0;
  localparam logic [SIZE_W-1:0]    CUBE_SIZE_RST = 15'd512;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X  = 2'd0,
    REG_ORIGIN_Y  = 2'd1,
    REG_ORIGIN_Z  = 2'd2,
    REG_CUBE_SIZE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                 action;
    logic [2:0]           corner;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic                 inside_res;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } out_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic                 query;
    logic                 in_cube;
    logic [2:0]           corner;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
    logic [SIZE_W-1:0]    d_x;
    logic [SIZE_W-1:0]    d_y;
    logic [SIZE_W-1:0]    d_z;
  } front_item_t;

endpackage

// ----- rtl/ctvi_front.sv -----
// Front end: registers each accepted item, runs the inside test and the offsets.
// Depends on ctvi_pkg.
`timescale 1ns / 1ps
module ctvi_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  ctvi_pkg::in_t                 in_item,
  input  logic signed [ctvi_pkg::CW-1:0] origin_x,
  input  logic signed [ctvi_pkg::CW-1:0] origin_y,
  input  logic signed [ctvi_pkg::CW-1:0] origin_z,
  input  logic [ctvi_pkg::SIZE_W-1:0]   cube_size,
  output logic                          fi_vld_r,
  output ctvi_pkg::front_item_t         fi_r
);

  logic signed [ctvi_pkg::CW:0] dx, dy, dz;
  logic                         in_x, in_y, in_z;
  ctvi_pkg::front_item_t        fi_nxt;

  always_comb begin
    dx = {in_item.pos_x[ctvi_pkg::CW-1], in_item.pos_x} - {origin_x[ctvi_pkg::CW-1], origin_x};
    dy = {in_item.pos_y[ctvi_pkg::CW-1], in_item.pos_y} - {origin_y[ctvi_pkg::CW-1], origin_y};
    dz = {in_item.pos_z[ctvi_pkg::CW-1], in_item.pos_z} - {origin_z[ctvi_pkg::CW-1], origin_z};
    // bounds inclusive on both sides
    in_x = !dx[ctvi_pkg::CW] && (dx[ctvi_pkg::CW-1:0] <= {1'b0, cube_size});
    in_y = !dy[ctvi_pkg::CW] && (dy[ctvi_pkg::CW-1:0] <= {1'b0, cube_size});
    in_z = !dz[ctvi_pkg::CW] && (dz[ctvi_pkg::CW-1:0] <= {1'b0, cube_size});
    fi_nxt.query   = (in_item.action == ctvi_pkg::ACT_QUERY);
    fi_nxt.in_cube = in_x && in_y && in_z;
    fi_nxt.corner  = in_item.corner;
    fi_nxt.vec_x   = in_item.vec_x;
    fi_nxt.vec_y   = in_item.vec_y;
    fi_nxt.vec_z   = in_item.vec_z;
    fi_nxt.d_x     = dx[ctvi_pkg::SIZE_W-1:0];
    fi_nxt.d_y     = dy[ctvi_pkg::SIZE_W-1:0];
    fi_nxt.d_z     = dz[ctvi_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_vld_r <= 1'b0;
    end else begin
      fi_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fi_r <= fi_nxt;
    end
  end

endmodule

// ----- rtl/ctvi_fifo.sv -----
// Two-entry item queue between the front end and the back end.
// Depends on ctvi_pkg.
`timescale 1ns / 1ps
module ctvi_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ctvi_pkg::front_item_t push_item,
  input  logic                  pop,
  output logic                  not_empty,
  output logic                  full,
  output ctvi_pkg::front_item_t head
);

  ctvi_pkg::front_item_t mem_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            count_r;

  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/ctvi_back.sv -----
// Back end: pipelined fraction divider, corner store and three blend stages.
// Depends on ctvi_pkg.
`timescale 1ns / 1ps
module ctvi_back #(
  parameter int FRAC_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  ctvi_pkg::front_item_t       in_item,
  input  logic [ctvi_pkg::SIZE_W-1:0] cube_size,
  output logic                        out_vld_r,
  output ctvi_pkg::out_t              out_r
);

  localparam int F  = FRAC_BITS;
  localparam int CW = ctvi_pkg::CW;
  localparam int AW = CW + F + 3;
  localparam logic signed [AW-1:0] ONE  = AW'(1) <<< F;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F - 1);
  localparam logic signed [AW-1:0] VMAX = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] VMIN = -(AW'(1) <<< (CW - 1));

  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic [F:0] t);
    logic signed [AW-1:0] tb, ta, acc;
    tb  = $signed({{(AW-F-1){1'b0}}, t});
    ta  = ONE - tb;
    acc = (AW'(a) * ta + AW'(b) * tb + HALF) >>> F;
    if (acc > VMAX) acc = VMAX;
    if (acc < VMIN) acc = VMIN;
    return acc[CW-1:0];
  endfunction

  // ---- divider: one quotient bit per stage, three axes side by side
  logic                  dv_vld_r  [F+1];
  ctvi_pkg::front_item_t dv_item_r [F+1];
  logic [CW-1:0]         dv_rem_r  [F+1][3];
  logic [F:0]            dv_q_r    [F+1][3];

  genvar i, k;
  generate
    for (i = 0; i <= F; i++) begin : g_div
      logic [CW-1:0] rem_in  [3];
      logic [F:0]    q_in    [3];
      logic [CW-1:0] rem_nxt [3];
      logic [F:0]    q_nxt   [3];
      logic          vld_in;
      ctvi_pkg::front_item_t item_in;

      if (i == 0) begin : g_first
        assign vld_in    = in_vld;
        assign item_in   = in_item;
        assign rem_in[0] = {1'b0, in_item.d_x};
        assign rem_in[1] = {1'b0, in_item.d_y};
        assign rem_in[2] = {1'b0, in_item.d_z};
        assign q_in[0]   = '0;
        assign q_in[1]   = '0;
        assign q_in[2]   = '0;
      end else begin : g_next
        assign vld_in  = dv_vld_r[i-1];
        assign item_in = dv_item_r[i-1];
        for (k = 0; k < 3; k++) begin : g_ax
          assign rem_in[k] = dv_rem_r[i-1][k] << 1;
          assign q_in[k]   = dv_q_r[i-1][k];
        end
      end

      for (k = 0; k < 3; k++) begin : g_step
        always_comb begin
          q_nxt[k] = q_in[k];
          if (rem_in[k] >= {1'b0, cube_size}) begin
            rem_nxt[k]    = rem_in[k] - {1'b0, cube_size};
            q_nxt[k][F-i] = 1'b1;
          end else begin
            rem_nxt[k] = rem_in[k];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_vld_r[i] <= 1'b0;
        end else begin
          dv_vld_r[i] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        dv_item_r[i] <= item_in;
        for (int a = 0; a < 3; a++) begin
          dv_rem_r[i][a] <= rem_nxt[a];
          dv_q_r[i][a]   <= q_nxt[a];
        end
      end
    end
  endgenerate

  // ---- corner store; loads land here in item order with the queries
  logic signed [CW-1:0]  cv_r [8][3];
  ctvi_pkg::front_item_t dv_last;
  logic [F:0]            t_frac [3];

  assign dv_last = dv_item_r[F];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // zero edge length: every fraction is zero
      t_frac[a] = (cube_size == '0) ? '0 : dv_q_r[F][a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < 3; a++) begin
          cv_r[c][a] <= '0;
        end
      end
    end else if (dv_vld_r[F] && !dv_last.query) begin
      cv_r[dv_last.corner][0] <= dv_last.vec_x;
      cv_r[dv_last.corner][1] <= dv_last.vec_y;
      cv_r[dv_last.corner][2] <= dv_last.vec_z;
    end
  end

  // ---- blend along x
  logic                 xs_vld_r, xs_in_r;
  logic [F:0]           xs_ty_r, xs_tz_r;
  logic signed [CW-1:0] xs_v_r [4][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_vld_r <= 1'b0;
    end else begin
      xs_vld_r <= dv_vld_r[F] && dv_last.query;
    end
  end

  always_ff @(posedge clk) begin
    xs_in_r <= dv_last.in_cube;
    xs_ty_r <= t_frac[1];
    xs_tz_r <= t_frac[2];
    for (int a = 0; a < 3; a++) begin
      xs_v_r[0][a] <= lerp(cv_r[0][a], cv_r[4][a], t_frac[0]);
      xs_v_r[1][a] <= lerp(cv_r[2][a], cv_r[6][a], t_frac[0]);
      xs_v_r[2][a] <= lerp(cv_r[1][a], cv_r[5][a], t_frac[0]);
      xs_v_r[3][a] <= lerp(cv_r[3][a], cv_r[7][a], t_frac[0]);
    end
  end

  // ---- blend along y
  logic                 ys_vld_r, ys_in_r;
  logic [F:0]           ys_tz_r;
  logic signed [CW-1:0] ys_v_r [2][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ys_vld_r <= 1'b0;
    end else begin
      ys_vld_r <= xs_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ys_in_r <= xs_in_r;
    ys_tz_r <= xs_tz_r;
    for (int a = 0; a < 3; a++) begin
      ys_v_r[0][a] <= lerp(xs_v_r[0][a], xs_v_r[1][a], xs_ty_r);
      ys_v_r[1][a] <= lerp(xs_v_r[2][a], xs_v_r[3][a], xs_ty_r);
    end
  end

  // ---- blend along z, result register
  logic signed [CW-1:0] zr [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      zr[a] = ys_in_r ? lerp(ys_v_r[0][a], ys_v_r[1][a], ys_tz_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= ys_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.inside_res <= ys_in_r;
    out_r.dir_x      <= zr[0];
    out_r.dir_y      <= zr[1];
    out_r.dir_z      <= zr[2];
  end

endmodule

// ----- rtl/cube_trilinear_vector_interp.sv -----
// Top level: configuration registers, front end, item queue and back end.
// Depends on ctvi_pkg, ctvi_front, ctvi_fifo, ctvi_back.
`timescale 1ns / 1ps
// Trilinear blend of eight corner vectors over one configured cube. One item
// is taken per clock; busy stays low in normal use since the back end drains
// the queue every cycle. A load item writes a corner and gives no result. A
// query gives one result on out_data, flagged by out_valid for a single
// cycle, after passing one front-end register, one queue slot, FRAC_BITS + 1
// divider stages (one quotient bit each) and three blend stages. The receiver
// cannot stall.
module cube_trilinear_vector_interp #(
  parameter int FRAC_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ctvi_pkg::in_t               in_data,
  output logic                        out_valid,
  output ctvi_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctvi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic signed [ctvi_pkg::CW-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic [ctvi_pkg::SIZE_W-1:0]    cube_size_r;
  ctvi_pkg::reg_idx_t             reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = ctvi_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= ctvi_pkg::ORIGIN_X_RST;
      origin_y_r  <= ctvi_pkg::ORIGIN_Y_RST;
      origin_z_r  <= ctvi_pkg::ORIGIN_Z_RST;
      cube_size_r <= ctvi_pkg::CUBE_SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ctvi_pkg::REG_ORIGIN_X:  origin_x_r  <= pwdata[ctvi_pkg::CW-1:0];
        ctvi_pkg::REG_ORIGIN_Y:  origin_y_r  <= pwdata[ctvi_pkg::CW-1:0];
        ctvi_pkg::REG_ORIGIN_Z:  origin_z_r  <= pwdata[ctvi_pkg::CW-1:0];
        ctvi_pkg::REG_CUBE_SIZE: cube_size_r <= pwdata[ctvi_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ctvi_pkg::REG_ORIGIN_X:  prdata = {{(32-ctvi_pkg::CW){1'b0}}, origin_x_r};
      ctvi_pkg::REG_ORIGIN_Y:  prdata = {{(32-ctvi_pkg::CW){1'b0}}, origin_y_r};
      ctvi_pkg::REG_ORIGIN_Z:  prdata = {{(32-ctvi_pkg::CW){1'b0}}, origin_z_r};
      ctvi_pkg::REG_CUBE_SIZE: prdata = {{(32-ctvi_pkg::SIZE_W){1'b0}}, cube_size_r};
      default:                 prdata = '0;
    endcase
  end

  logic                  accept;
  logic                  fi_vld;
  ctvi_pkg::front_item_t fi;
  logic                  q_not_empty, q_full;
  ctvi_pkg::front_item_t q_head;

  assign busy   = q_full;
  assign accept = start && !busy;

  ctvi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .origin_z  (origin_z_r),
    .cube_size (cube_size_r),
    .fi_vld_r  (fi_vld),
    .fi_r      (fi)
  );

  ctvi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fi_vld),
    .push_item (fi),
    .pop       (q_not_empty),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (q_head)
  );

  ctvi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (q_not_empty),
    .in_item   (q_head),
    .cube_size (cube_size_r),
    .out_vld_r (out_valid),
    .out_r     (out_data)
  );

  // back end drains one item per cycle, so the queue never fills
  a_never_full: assert property (@(posedge clk) disable iff (!rst_n) !q_full)
    else $error("item queue filled");

  // an item outside the cube always reports a zero vector
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_data.inside_res |->
      out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
    else $error("non-zero vector for outside item");

  // each queued query leads to a result later
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
      q_not_empty && q_head.query |-> ##(FRAC_BITS + 4) out_valid)
    else $error("query result missing");

endmodule
